FILE: sv/idv_pkg.sv
package idv_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_ACCEPT   = 3'd1,
      ST_OK       = 3'd2,
      ST_FAIL     = 3'd3,
      ST_REJECT   = 3'd4,
      ST_START_OK = 3'd5
   } status_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_IMAGE_SIZE   = 2'd0,
      CSR_EXPECTED_CRC = 2'd1,
      CSR_MODULE_TYPE  = 2'd2
   } csr_index_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam int unsigned SIZE_W  = 17;
   localparam int unsigned CRC_W   = 32;
   localparam int unsigned TYPE_W  = 8;
   localparam int unsigned COUNT_W = 18;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [CRC_W-1:0]    final_crc;
      logic [COUNT_W-1:0]  bytes_received;
   } rsp_type;

   // reflected crc-32 nibble table, polynomial 0xedb88320
   function automatic logic [CRC_W-1:0] crc_nibble(input logic [3:0] idx);
      logic [CRC_W-1:0] val;
      case (idx)
         4'h0: val = 32'h0000_0000;
         4'h1: val = 32'h1DB7_1064;
         4'h2: val = 32'h3B6E_20C8;
         4'h3: val = 32'h26D9_30AC;
         4'h4: val = 32'h76DC_4190;
         4'h5: val = 32'h6B6B_51F4;
         4'h6: val = 32'h4DB2_6158;
         4'h7: val = 32'h5005_713C;
         4'h8: val = 32'hEDB8_8320;
         4'h9: val = 32'hF00F_9344;
         4'hA: val = 32'hD6D6_A3E8;
         4'hB: val = 32'hCB61_B38C;
         4'hC: val = 32'h9B64_C2B0;
         4'hD: val = 32'h86D3_D2D4;
         4'hE: val = 32'hA00A_E278;
         default: val = 32'hBDBD_F21C;
      endcase
      return val;
   endfunction

endpackage

FILE: sv/idv_crc_byte.sv
module idv_crc_byte (
   input  logic [idv_pkg::CRC_W-1:0] crc_cur,
   input  logic [7:0]                data_byte,
   output logic [idv_pkg::CRC_W-1:0] crc_next
);
   import idv_pkg::*;

   logic [CRC_W-1:0] mix;
   logic [CRC_W-1:0] half;

   // two nibble steps, low nibble first
   always_comb begin
      mix      = crc_cur ^ {24'd0, data_byte};
      half     = (mix >> 4) ^ crc_nibble(mix[3:0]);
      crc_next = (half >> 4) ^ crc_nibble(half[3:0]);
   end

endmodule

FILE: sv/image_download_verifier_core.sv
// channel | ports                                  | moves
// req     | req_valid, req_ready, req_payload      | start or data byte transaction in
// rsp     | rsp_valid, rsp_ready, rsp_payload      | one status transaction per request
// csr     | csr_we, csr_index, csr_wdata           | register write, no wait
//
// each request is evaluated in the cycle it is accepted and its response is
// registered; the response shows in the next cycle, one request per cycle
// the single response register sets the rate: req_ready is high while it is
// empty or being drained in the same cycle, so a stalled rsp stalls req
// reset (synchronous, active high) closes any session, presets the crc to
// all ones, clears the byte count, the registers and the response valid flag
module image_download_verifier_core #(
   parameter int unsigned MAX_IMAGE_BYTES = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  idv_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output idv_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  idv_pkg::csr_index_type              csr_index,
   input  logic [idv_pkg::CRC_W-1:0]           csr_wdata
);
   import idv_pkg::*;

   localparam logic [COUNT_W-1:0] MaxBytes = COUNT_W'(MAX_IMAGE_BYTES);
   localparam logic [COUNT_W-1:0] CountMax = '1;

   // configuration registers
   logic [SIZE_W-1:0] image_size_ff;
   logic [CRC_W-1:0]  expected_crc_ff;
   logic [TYPE_W-1:0] module_type_ff;

   // session state
   logic               active_ff,  active_in;
   logic [CRC_W-1:0]   crc_ff,     crc_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic [SIZE_W-1:0]  ssize_ff,   ssize_in;
   logic [CRC_W-1:0]   scrc_ff,    scrc_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;

   logic               req_fire;
   logic               start_reject;
   logic [CRC_W-1:0]   crc_step;
   logic [COUNT_W-1:0] count_step;
   logic [COUNT_W-1:0] ssize_ext;
   status_type         status;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // byte-wide crc update on the running register
   idv_crc_byte u_crc_byte (
      .crc_cur   (crc_ff),
      .data_byte (req_payload.data_byte),
      .crc_next  (crc_step)
   );

   assign ssize_ext  = {1'b0, ssize_ff};
   assign count_step = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;

   // start is refused on an open session, a zero module type or a bad size
   assign start_reject = active_ff || (module_type_ff == '0) || (image_size_ff == '0) ||
                         ({1'b0, image_size_ff} > MaxBytes);

   always_comb begin
      active_in = active_ff;
      crc_in    = crc_ff;
      count_in  = count_ff;
      ssize_in  = ssize_ff;
      scrc_in   = scrc_ff;
      status    = ST_IDLE;
      if (req_payload.op == OP_START) begin
         if (start_reject) begin
            status = ST_REJECT;
         end else begin
            active_in = 1'b1;
            ssize_in  = image_size_ff;
            scrc_in   = expected_crc_ff;
            crc_in    = '1;
            count_in  = '0;
            status    = ST_START_OK;
         end
      end else if (active_ff) begin
         crc_in   = crc_step;
         count_in = count_step;
         status   = ST_ACCEPT;
         // completion is checked only on a chunk end
         if (req_payload.end_of_chunk && (count_step >= ssize_ext)) begin
            active_in = 1'b0;
            if ((count_step == ssize_ext) && (~crc_step == scrc_ff)) begin
               status = ST_OK;
            end else begin
               status = ST_FAIL;
            end
         end
      end
   end

   always_comb begin
      rsp_in.status         = status;
      rsp_in.final_crc      = ~crc_in;
      rsp_in.bytes_received = count_in;
      rsp_valid_in          = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff   <= '0;
         expected_crc_ff <= '0;
         module_type_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_SIZE:   image_size_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_EXPECTED_CRC: expected_crc_ff <= csr_wdata;
            CSR_MODULE_TYPE:  module_type_ff  <= csr_wdata[TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         crc_ff       <= '1;
         count_ff     <= '0;
         ssize_ff     <= '0;
         scrc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            active_ff <= active_in;
            crc_ff    <= crc_in;
            count_ff  <= count_in;
            ssize_ff  <= ssize_in;
            scrc_ff   <= scrc_in;
         end
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: sv/idv_checker.sv
module idv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input idv_pkg::rsp_type rsp_payload
);
   import idv_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // every accepted request shows a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // input only stalls behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output backpressure");

   // a started session reports empty state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_START_OK) |->
      (rsp_payload.final_crc == '0) && (rsp_payload.bytes_received == '0))
      else $error("session start with nonzero crc or count");

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind image_download_verifier_core idv_checker u_idv_checker (.*);

FILE: test/image_download_verifier_core_tb.sv
`timescale 1ns / 1ps

import idv_pkg::*;

// one byte through the reflected crc-32, bit by bit
function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                              input logic [7:0] octet);
   logic [CRC_W-1:0] c;
   c = crc ^ {24'h0, octet};
   for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ 32'hEDB8_8320;
      else c = c >> 1;
   end
   return c;
endfunction

class download_tracker #(int unsigned MAX_BYTES = 65536);
   logic [SIZE_W-1:0]  image_size;
   logic [CRC_W-1:0]   expected_crc;
   logic [TYPE_W-1:0]  module_type;
   bit                 in_session;
   logic [CRC_W-1:0]   crc_state;
   logic [COUNT_W-1:0] byte_count;
   logic [SIZE_W-1:0]  locked_size;
   logic [CRC_W-1:0]   locked_crc;
   rsp_type            pending_status[$];
   int unsigned        failures;

   function new();
      image_size   = '0;
      expected_crc = '0;
      module_type  = '0;
      in_session   = 1'b0;
      crc_state    = '1;
      byte_count   = '0;
      locked_size  = '0;
      locked_crc   = '0;
      failures     = 0;
   endfunction

   function void set_register(csr_index_type idx, logic [CRC_W-1:0] value);
      case (idx)
         CSR_IMAGE_SIZE:   image_size = value[SIZE_W-1:0];
         CSR_EXPECTED_CRC: expected_crc = value;
         CSR_MODULE_TYPE:  module_type = value[TYPE_W-1:0];
         default: ;
      endcase
   endfunction

   function void take_request(req_type r);
      rsp_type want;
      want.status = ST_IDLE;
      if (r.op == OP_START) begin
         if (in_session || module_type == 0 || image_size == 0 || image_size > MAX_BYTES) begin
            want.status = ST_REJECT;
         end else begin
            in_session  = 1'b1;
            locked_size = image_size;
            locked_crc  = expected_crc;
            crc_state   = '1;
            byte_count  = '0;
            want.status = ST_START_OK;
         end
      end else if (in_session) begin
         crc_state = crc_step(crc_state, r.data_byte);
         if (byte_count != '1) byte_count = byte_count + 1'b1;
         want.status = ST_ACCEPT;
         if (r.end_of_chunk && byte_count >= locked_size) begin
            in_session = 1'b0;
            want.status = (byte_count == locked_size && ~crc_state == locked_crc) ?
                          ST_OK : ST_FAIL;
         end
      end
      want.final_crc      = ~crc_state;
      want.bytes_received = byte_count;
      pending_status.push_back(want);
   endfunction

   function void report(string what, logic [CRC_W-1:0] exp_val, logic [CRC_W-1:0] act_val);
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, act_val);
   endfunction

   function void check_status(rsp_type got);
      rsp_type want;
      if (pending_status.size() == 0) begin
         report("unexpected response", '0, got.final_crc);
         return;
      end
      want = pending_status.pop_front();
      if (got.status !== want.status)
         report("status", CRC_W'(want.status), CRC_W'(got.status));
      if (got.final_crc !== want.final_crc) report("final_crc", want.final_crc, got.final_crc);
      if (got.bytes_received !== want.bytes_received)
         report("bytes_received", CRC_W'(want.bytes_received), CRC_W'(got.bytes_received));
   endfunction
endclass

module image_download_verifier_core_tb;

   localparam int unsigned MAX_IMAGE = 65536;
   // watchdog limit for the whole run
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned RANDOM_ITEMS = 1850;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_we = 1'b0;
   csr_index_type     csr_index = CSR_IMAGE_SIZE;
   logic [CRC_W-1:0]  csr_wdata = '0;

   int unsigned       idle_pct = 0;
   int unsigned       stall_pct = 0;
   int unsigned       cycles = 0;

   download_tracker #(MAX_IMAGE) tracker;

   image_download_verifier_core #(.MAX_IMAGE_BYTES(MAX_IMAGE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side: random back-pressure on the status channel
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: check responses before noting the request of the same edge,
   // a response always belongs to an earlier transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_status(rsp_payload);
         if (req_valid && req_ready) tracker.take_request(req_payload);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // crc-32 of a whole image, as the block reports it at the end
   function automatic logic [CRC_W-1:0] checksum_of(input logic [7:0] img[$]);
      logic [CRC_W-1:0] c;
      c = '1;
      foreach (img[i]) c = crc_step(c, img[i]);
      return ~c;
   endfunction

   // one transaction on the request channel; valid stays up between
   // back-to-back transactions and only drops for an idle gap
   task automatic send(input logic op, input logic [7:0] octet, input logic eoc);
      req_type item;
      item.op           = op;
      item.data_byte    = octet;
      item.end_of_chunk = eoc;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every expected response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_status.size() != 0) @(posedge clock);
      // wait past the response register
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CRC_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] size, input logic [CRC_W-1:0] crc,
                            input logic [TYPE_W-1:0] mtype);
      write_reg(CSR_IMAGE_SIZE, {15'h0, size});
      write_reg(CSR_EXPECTED_CRC, crc);
      write_reg(CSR_MODULE_TYPE, {24'h0, mtype});
   endtask

   // feed bytes with chunk ends until the open session closes
   task automatic close_session();
      while (tracker.in_session) begin
         send(OP_DATA, 8'($urandom_range(255)), 1'b1);
         settle();
      end
   endtask

   // well-formed download with random content and occasional damage;
   // returns the number of transactions sent
   task automatic image_session(output int unsigned sent);
      logic [7:0]        img[$];
      int unsigned       len;
      int unsigned       r;
      logic [SIZE_W-1:0] size;
      logic              eoc;
      len = ($urandom_range(19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) img.push_back(8'($urandom_range(255)));
      size = SIZE_W'(len);
      r = $urandom_range(9);
      if (r == 0) size = SIZE_W'(len + $urandom_range(1, 3));
      else if (r == 1 && len > 1) size = SIZE_W'($urandom_range(1, len - 1));
      configure(size, ($urandom_range(4) == 0) ? $urandom : checksum_of(img),
                ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      send(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
      sent = 1;
      for (int i = 0; i < len; i++) begin
         if (i == len / 2 && $urandom_range(9) == 0) begin
            // mid-session: a stray start, or register writes that must not
            // touch the open session
            if ($urandom_range(1)) begin
               send(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
               sent++;
            end else begin
               settle();
               configure(17'($urandom_range(1, 8)), $urandom, 8'($urandom_range(255)));
            end
         end
         eoc = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(3) == 0);
         send(OP_DATA, img[i], eoc);
         sent++;
      end
      settle();
      close_session();
   endtask

   // random transactions, possibly with bad register settings
   task automatic noise_burst();
      int unsigned n;
      int unsigned pick;
      if ($urandom_range(1)) begin
         pick = $urandom_range(3);
         configure((pick == 0) ? 17'd0 :
                   (pick == 1) ? 17'($urandom_range(65537, 131071)) :
                                 17'($urandom_range(1, 8)),
                   $urandom, 8'($urandom_range(255)));
      end
      n = $urandom_range(1, 10);
      repeat (n) send(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      settle();
      close_session();
   endtask

   initial begin
      logic [7:0]  img[$];
      int unsigned random_sent;
      int unsigned sent;
      int unsigned sessions;
      int unsigned phase;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, no idling ---
      // byte while idle, then start with all registers still zero
      send(OP_DATA, 8'hFF, 1'b1);
      send(OP_START, 8'h00, 1'b0);
      settle();
      // image size zero, then just above the maximum, then the top of the field
      configure(17'd0, 32'h0, 8'hFF);
      send(OP_START, 8'hFF, 1'b1);
      settle();
      write_reg(CSR_IMAGE_SIZE, MAX_IMAGE + 1);
      send(OP_START, 8'h00, 1'b1);
      settle();
      write_reg(CSR_IMAGE_SIZE, 32'h1FFFF);
      send(OP_START, 8'h00, 1'b0);
      settle();
      // single-byte image that passes
      img = {8'h00};
      configure(17'd1, checksum_of(img), 8'h01);
      send(OP_START, 8'hFF, 1'b1);
      send(OP_DATA, 8'h00, 1'b1);
      settle();
      // start while active, early chunk end, count passing the size without
      // a chunk end, close with count above size, then a byte while idle
      configure(17'd3, 32'hFFFF_FFFF, 8'h7E);
      send(OP_START, 8'h00, 1'b0);
      send(OP_START, 8'hFF, 1'b1);
      send(OP_DATA, 8'hFF, 1'b0);
      send(OP_DATA, 8'h00, 1'b1);
      send(OP_DATA, 8'h80, 1'b0);
      send(OP_DATA, 8'h01, 1'b0);
      send(OP_DATA, 8'h7F, 1'b1);
      send(OP_DATA, 8'h55, 1'b1);
      settle();
      // count equals size but the crc is wrong
      configure(17'd1, 32'h0, 8'h01);
      send(OP_START, 8'h00, 1'b0);
      send(OP_DATA, 8'hAA, 1'b1);
      settle();
      // registers rewritten inside a session are latched only at a start
      img = {8'h01, 8'h02};
      configure(17'd2, checksum_of(img), 8'h02);
      send(OP_START, 8'h00, 1'b0);
      settle();
      configure(17'd5, 32'h0, 8'h00);
      send(OP_DATA, 8'h01, 1'b0);
      send(OP_DATA, 8'h02, 1'b1);
      settle();

      // --- random part: mostly well-formed downloads, some noise ---
      random_sent = 0;
      sessions = 0;
      while (random_sent < RANDOM_ITEMS) begin
         // cycle through the idling profiles every few sessions
         phase = (sessions / 6) % 4;
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         if ($urandom_range(3) == 0) begin
            noise_burst();
         end else begin
            image_session(sent);
            random_sent += sent;
         end
         sessions++;
      end

      settle();
      repeat (4) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_status.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/idv_pkg.sv
sv/idv_crc_byte.sv
sv/image_download_verifier_core.sv
sv/idv_checker.sv
test/image_download_verifier_core_tb.sv
